[hdl/mbe_pkg.sv]
// Shared constants and types for the Mandelbrot escape magnitude block.
package mbe_pkg;

    // Fixed point format and iteration counter
    localparam int FRAC_BITS = 28;
    localparam int ITER_BITS = 16;

    // Field widths
    localparam int IN_W    = 32;
    localparam int OUT_W   = 36;
    localparam int THR_W   = 32;
    localparam int MAXIT_W = 16;

    // Iterate x, y stay below 2^32 + 2^31 in magnitude while the loop runs
    localparam int XY_W   = 34;
    localparam int MAG_W  = XY_W - 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int SQ_W   = PROD_W - FRAC_BITS;
    localparam int P_W    = THR_W;
    localparam int SAT_W  = (SQ_W + 1 > OUT_W + 1) ? SQ_W + 1 : OUT_W + 1;
    localparam int LIM_W  = (ITER_BITS > MAXIT_W) ? ITER_BITS : MAXIT_W;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
    localparam logic [THR_W-1:0] THR_RESET =
        (FRAC_BITS <= 30) ? THR_W'(64'd3 << FRAC_BITS) : {THR_W{1'b1}};

    // Work queue between front and core, depth a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // APB port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef struct packed {
        logic [IN_W-1:0]      cr;
        logic [IN_W-1:0]      ci;
        logic [ITER_BITS-1:0] limit;
        logic [THR_W-1:0]     thr;
        logic                 trivial;
    } item_t;

endpackage

[hdl/mbe_front.sv]
// Front end: accepts points, snapshots config, flags trivial words, queues them.
module mbe_front
    import mbe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [IN_W-1:0]        point_real,
    input  logic [IN_W-1:0]        point_imag,
    input  logic [MAXIT_W-1:0]     max_iterations,
    input  logic [THR_W-1:0]       escape_threshold,
    output logic                   q_valid,
    input  logic                   q_pop,
    output item_t                  q_word
);

    item_t                q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 push;
    logic                 pop;
    logic [LIM_W-1:0]     mi_ext;
    logic [LIM_W-1:0]     cmax_ext;
    logic [ITER_BITS-1:0] limit;
    item_t                new_word;

    // clamp limit to what the counter can hold
    assign mi_ext   = LIM_W'(max_iterations);
    assign cmax_ext = LIM_W'({ITER_BITS{1'b1}});
    assign limit    = (mi_ext > cmax_ext) ? ITER_BITS'(cmax_ext) : ITER_BITS'(mi_ext);

    always_comb
    begin
        new_word.cr      = point_real;
        new_word.ci      = point_imag;
        new_word.limit   = limit;
        new_word.thr     = escape_threshold;
        // no iteration runs: result is 0 without the core loop
        new_word.trivial = (limit == '0) || (escape_threshold == '0);
    end

    assign in_stall = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_word   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_word;
        end
    end

endmodule

[hdl/mbe_core.sv]
// Iteration core: three-product multiply step, update step and result register.
module mbe_core
    import mbe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_pop,
    input  item_t             q_word,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [OUT_W-1:0]  escape_magnitude
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;
    logic [IN_W-1:0]      cr_reg, cr_next;
    logic [IN_W-1:0]      ci_reg, ci_next;
    logic [ITER_BITS-1:0] limit_reg, limit_next;
    logic [THR_W-1:0]     thr_reg, thr_next;
    logic [ITER_BITS-1:0] iter_reg, iter_next;
    logic [MAG_W-1:0]     xm_reg, xm_next;
    logic [MAG_W-1:0]     ym_reg, ym_next;
    logic                 xs_reg, xs_next;
    logic                 ys_reg, ys_next;
    logic [PROD_W-1:0]    pxx_reg, pxx_next;
    logic [PROD_W-1:0]    pyy_reg, pyy_next;
    logic [PROD_W-1:0]    pxy_reg, pxy_next;
    logic                 neg_reg, neg_next;

    logic                 out_free;
    logic [SQ_W-1:0]      x2;
    logic [SQ_W-1:0]      y2;
    logic [P_W-1:0]       p;
    logic [SAT_W-1:0]     sum;
    logic                 go_on;
    logic [XY_W-1:0]      cr_ext;
    logic [XY_W-1:0]      ci_ext;
    logic [XY_W-1:0]      twoxy;
    logic [XY_W-1:0]      nx;
    logic [XY_W-1:0]      ny;
    logic [XY_W-1:0]      nx_neg;
    logic [XY_W-1:0]      ny_neg;
    logic [OUT_W-1:0]     result;

    assign out_free = !out_valid_reg || !out_stall;

    // truncated squares and 2xy magnitude
    assign x2 = SQ_W'(pxx_reg >> FRAC_BITS);
    assign y2 = SQ_W'(pyy_reg >> FRAC_BITS);
    assign p  = P_W'(pxy_reg >> (FRAC_BITS - 1));

    assign sum   = SAT_W'(x2) + SAT_W'(y2);
    assign go_on = (iter_reg < limit_reg) && (sum < SAT_W'(thr_reg));

    assign cr_ext = {{(XY_W - IN_W){cr_reg[IN_W-1]}}, cr_reg};
    assign ci_ext = {{(XY_W - IN_W){ci_reg[IN_W-1]}}, ci_reg};

    // while the loop runs x2, y2 < 2^32, so modulo 2^XY_W is exact
    assign twoxy  = neg_reg ? (XY_W'(0) - XY_W'(p)) : XY_W'(p);
    assign nx     = XY_W'(x2) - XY_W'(y2) + cr_ext;
    assign ny     = twoxy + ci_ext;
    assign nx_neg = XY_W'(0) - nx;
    assign ny_neg = XY_W'(0) - ny;

    assign result = (iter_reg >= limit_reg) ? '0 :
                    (sum > SAT_W'(OUT_MAX)) ? OUT_MAX : sum[OUT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        limit_next     = limit_reg;
        thr_next       = thr_reg;
        iter_next      = iter_reg;
        xm_next        = xm_reg;
        ym_next        = ym_reg;
        xs_next        = xs_reg;
        ys_next        = ys_reg;
        pxx_next       = pxx_reg;
        pyy_next       = pyy_reg;
        pxy_next       = pxy_reg;
        neg_next       = neg_reg;
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_word.trivial)
                    begin
                        if (out_free)
                        begin
                            q_pop          = 1'b1;
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                        end
                    end
                    else
                    begin
                        // z = 0: zero products make the first update load c
                        q_pop      = 1'b1;
                        cr_next    = q_word.cr;
                        ci_next    = q_word.ci;
                        limit_next = q_word.limit;
                        thr_next   = q_word.thr;
                        iter_next  = '0;
                        pxx_next   = '0;
                        pyy_next   = '0;
                        pxy_next   = '0;
                        neg_next   = 1'b0;
                        state_next = ST_UPD;
                    end
                end
            end
            ST_MUL:
            begin
                pxx_next   = PROD_W'(xm_reg) * PROD_W'(xm_reg);
                pyy_next   = PROD_W'(ym_reg) * PROD_W'(ym_reg);
                pxy_next   = PROD_W'(xm_reg) * PROD_W'(ym_reg);
                neg_next   = xs_reg ^ ys_reg;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (go_on)
                begin
                    xs_next    = nx[XY_W-1];
                    ys_next    = ny[XY_W-1];
                    xm_next    = nx[XY_W-1] ? nx_neg[MAG_W-1:0] : nx[MAG_W-1:0];
                    ym_next    = ny[XY_W-1] ? ny_neg[MAG_W-1:0] : ny[MAG_W-1:0];
                    iter_next  = iter_reg + 1'b1;
                    state_next = ST_MUL;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        cr_reg       <= cr_next;
        ci_reg       <= ci_next;
        limit_reg    <= limit_next;
        thr_reg      <= thr_next;
        iter_reg     <= iter_next;
        xm_reg       <= xm_next;
        ym_reg       <= ym_next;
        xs_reg       <= xs_next;
        ys_reg       <= ys_next;
        pxx_reg      <= pxx_next;
        pyy_reg      <= pyy_next;
        pxy_reg      <= pxy_next;
        neg_reg      <= neg_next;
    end

    assign out_valid        = out_valid_reg;
    assign escape_magnitude = out_data_reg;

endmodule

[hdl/mandelbrot_escape_magnitude.sv]
// Top level: Mandelbrot escape magnitude with APB config registers.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_stall  | point_real, point_imag (signed Q4.28)
//  out      | out_valid / out_stall| escape_magnitude (unsigned Q8.28, sat)
//  cfg      | APB psel/penable     | 0x0 max_iterations, 0x4 escape_threshold
//
// A point that runs N iterations holds the core for a load step, an update
// (escape compare, new z) and a multiply (three 33x33 products) per
// iteration, then a final update; zero limit or threshold: the load step only.
// Reset (rst_n, async, active low) empties the queue and output register;
// max_iterations resets to 0, escape_threshold to 3.0.
// A two-word queue takes new points while the core iterates or out is stalled.
module mandelbrot_escape_magnitude
    import mbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [IN_W-1:0]    point_real,
    input  logic [IN_W-1:0]    point_imag,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [OUT_W-1:0]   escape_magnitude,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // register index lives in paddr[2]
    localparam logic REG_MAX_IT = 1'b0;
    localparam logic REG_THR    = 1'b1;

    logic [MAXIT_W-1:0] max_it_reg, max_it_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    logic               cfg_wr;
    logic               q_valid;
    logic               q_pop;
    item_t              q_word;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        max_it_next = max_it_reg;
        thr_next    = thr_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_MAX_IT: max_it_next = pwdata[MAXIT_W-1:0];
                REG_THR:    thr_next    = pwdata[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MAX_IT: prdata = PDATA_W'(max_it_reg);
            REG_THR:    prdata = PDATA_W'(thr_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_it_reg <= '0;
            thr_reg    <= THR_RESET;
        end
        else
        begin
            max_it_reg <= max_it_next;
            thr_reg    <= thr_next;
        end
    end

    // front: accept, clamp limit, flag trivial words, queue
    mbe_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .point_real       (point_real),
        .point_imag       (point_imag),
        .max_iterations   (max_it_reg),
        .escape_threshold (thr_reg),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_word           (q_word)
    );

    // back: z = z^2 + c loop and result register
    mbe_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_word           (q_word),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .escape_magnitude (escape_magnitude)
    );

endmodule
